### hw/rtl/md_pkg.sv
// ----------------------------------------------------------------------------
// Multiply-divide package
// Widths, status and opcode codes, and the work record that travels down the
// division pipeline.
// ----------------------------------------------------------------------------
package md_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int PORT_WIDTH    = 32;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic {
      MD_OP_SIGNED   = 1'b0,
      MD_OP_UNSIGNED = 1'b1
   } md_opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      MD_ST_OK   = 2'd0,
      MD_ST_DIV0 = 2'd1,
      MD_ST_OVF  = 2'd2
   } md_status_type;

   typedef struct packed {
      logic                     uns;
      logic                     neg;
      logic                     div0;
      logic                     ovf;
      logic [OPERAND_WIDTH-1:0] dmag;
      logic [OPERAND_WIDTH-1:0] rem;
      logic [OPERAND_WIDTH-1:0] quo;
   } md_work_type;

endpackage

### hw/rtl/md_if.sv
// ----------------------------------------------------------------------------
// Multiply-divide channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface md_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [md_pkg::PORT_WIDTH-1:0] operand_a;
   logic [md_pkg::PORT_WIDTH-1:0] operand_b;
   logic [md_pkg::PORT_WIDTH-1:0] divisor;

   modport source (output valid, opcode, operand_a, operand_b, divisor, input ready);
   modport sink (input valid, opcode, operand_a, operand_b, divisor, output ready);
endinterface

interface md_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [md_pkg::PORT_WIDTH-1:0]   quotient;
   logic [md_pkg::STATUS_WIDTH-1:0] status;

   modport source (output valid, quotient, status, input ready);
   modport sink (input valid, quotient, status, output ready);
endinterface

### hw/rtl/muldiv_64_by_32_top.sv
// ----------------------------------------------------------------------------
// Multiply-divide top level
// Forms the double-width product of two operands and divides it by a third,
// signed truncating or unsigned rounding, with a status for zero divisor and
// quotient overflow.
//
//   Channel   Direction   Carries
//   req_if    in          opcode, operand_a, operand_b, divisor
//   rsp_if    out         quotient, status
//
// An item enters every cycle while the response is taken; its result passes
// through the front end, one restoring step per stage, and the back end.
// Every stage has its own valid bit and takes a new item whenever it is empty
// or its successor moves, so a stalled response only halts what queues up
// behind it and nothing is dropped or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module muldiv_64_by_32_top (
   input  logic     clock,
   input  logic     reset,
   md_req_if.sink   req_if,
   md_rsp_if.source rsp_if
);

   localparam int W = md_pkg::OPERAND_WIDTH;

   logic                valid_chain [W+1];
   logic                ready_chain [W+1];
   md_pkg::md_work_type work_chain  [W+1];

   md_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_work  (work_chain[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_div
      md_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_work   (work_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_work  (work_chain[i+1])
      );
   end

   md_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_chain[W]),
      .in_ready (ready_chain[W]),
      .in_work  (work_chain[W]),
      .rsp_if   (rsp_if)
   );

endmodule

### hw/rtl/md_front.sv
// ----------------------------------------------------------------------------
// Multiply-divide front end
// Three stages: operand magnitudes and signs, the double-width product, then
// the rounding addend and the quotient range check.
// ----------------------------------------------------------------------------
module md_front (
   input  logic                clock,
   input  logic                reset,
   md_req_if.sink              req_if,
   output logic                out_valid,
   input  logic                out_ready,
   output md_pkg::md_work_type out_work
);

   localparam int W = md_pkg::OPERAND_WIDTH;

   typedef struct packed {
      logic         uns;
      logic         neg;
      logic         div0;
      logic [W-1:0] amag;
      logic [W-1:0] bmag;
      logic [W-1:0] dmag;
   } md_mag_type;

   typedef struct packed {
      logic           uns;
      logic           neg;
      logic           div0;
      logic [W-1:0]   dmag;
      logic [2*W-1:0] prod;
   } md_prod_type;

   logic                v0_ff, v1_ff, v2_ff;
   logic                rdy0, rdy1, rdy2;
   md_mag_type          s0_ff, s0_in;
   md_prod_type         s1_ff, s1_in;
   md_pkg::md_work_type s2_ff, s2_in;

   logic [W-1:0]   a_raw, b_raw, c_raw;
   logic           uns;
   logic [2*W-1:0] num;

   always_comb begin
      rdy2 = !v2_ff || out_ready;
      rdy1 = !v1_ff || rdy2;
      rdy0 = !v0_ff || rdy1;
   end

   assign req_if.ready = rdy0;

   always_comb begin
      a_raw = req_if.operand_a[W-1:0];
      b_raw = req_if.operand_b[W-1:0];
      c_raw = req_if.divisor[W-1:0];
      uns   = (req_if.opcode == md_pkg::MD_OP_UNSIGNED);
      s0_in.uns  = uns;
      s0_in.div0 = (c_raw == '0);
      s0_in.neg  = !uns && (a_raw[W-1] ^ b_raw[W-1] ^ c_raw[W-1]);
      s0_in.amag = (!uns && a_raw[W-1]) ? (W'(0) - a_raw) : a_raw;
      s0_in.bmag = (!uns && b_raw[W-1]) ? (W'(0) - b_raw) : b_raw;
      s0_in.dmag = (!uns && c_raw[W-1]) ? (W'(0) - c_raw) : c_raw;
   end

   always_comb begin
      s1_in.uns  = s0_ff.uns;
      s1_in.neg  = s0_ff.neg;
      s1_in.div0 = s0_ff.div0;
      s1_in.dmag = s0_ff.dmag;
      s1_in.prod = (2*W)'(s0_ff.amag) * (2*W)'(s0_ff.bmag);
   end

   always_comb begin
      num = s1_ff.prod + (s1_ff.uns ? (2*W)'(s1_ff.dmag >> 1) : '0);
      s2_in.uns  = s1_ff.uns;
      s2_in.neg  = s1_ff.neg;
      s2_in.div0 = s1_ff.div0;
      s2_in.dmag = s1_ff.dmag;
      s2_in.ovf  = (num[2*W-1:W] >= s1_ff.dmag);
      s2_in.rem  = num[2*W-1:W];
      s2_in.quo  = num[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_if.valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) s0_ff <= s0_in;
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_work  = s2_ff;

endmodule

### hw/rtl/md_div_stage.sv
// ----------------------------------------------------------------------------
// Multiply-divide division stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module md_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  md_pkg::md_work_type in_work,
   output logic                out_valid,
   input  logic                out_ready,
   output md_pkg::md_work_type out_work
);

   localparam int W = md_pkg::OPERAND_WIDTH;

   logic                valid_ff;
   md_pkg::md_work_type work_ff, work_in;
   logic [W:0]          trial;
   logic [W:0]          diff;
   logic                take;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial   = {in_work.rem, in_work.quo[W-1]};
      diff    = trial - {1'b0, in_work.dmag};
      take    = (trial >= {1'b0, in_work.dmag});
      work_in     = in_work;
      work_in.rem = take ? diff[W-1:0] : trial[W-1:0];
      work_in.quo = {in_work.quo[W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

### hw/rtl/md_back.sv
// ----------------------------------------------------------------------------
// Multiply-divide back end
// Applies the sign, checks the signed range, sets the status and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module md_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  md_pkg::md_work_type in_work,
   md_rsp_if.source            rsp_if
);

   localparam int W = md_pkg::OPERAND_WIDTH;
   localparam int P = md_pkg::PORT_WIDTH;

   logic                  valid_ff;
   logic [P-1:0]          quotient_ff, quotient_in;
   md_pkg::md_status_type status_ff, status_in;
   logic                  range_ovf;
   logic [W-1:0]          signed_q;

   assign in_ready = !valid_ff || rsp_if.ready;

   always_comb begin
      signed_q = in_work.neg ? (W'(0) - in_work.quo) : in_work.quo;
      if (in_work.uns) begin
         range_ovf = 1'b0;
      end else if (in_work.neg) begin
         range_ovf = in_work.quo[W-1] && (in_work.quo[W-2:0] != '0);
      end else begin
         range_ovf = in_work.quo[W-1];
      end
      priority if (in_work.div0) begin
         status_in   = md_pkg::MD_ST_DIV0;
         quotient_in = '0;
      end else if (in_work.ovf || range_ovf) begin
         status_in   = md_pkg::MD_ST_OVF;
         quotient_in = '0;
      end else begin
         status_in   = md_pkg::MD_ST_OK;
         quotient_in = P'(signed_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         quotient_ff <= quotient_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.quotient = quotient_ff;
   assign rsp_if.status   = status_ff;

endmodule

### hw/rtl/md_checker.sv
// ----------------------------------------------------------------------------
// Multiply-divide checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module md_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [md_pkg::PORT_WIDTH-1:0]   quotient,
   input logic [md_pkg::STATUS_WIDTH-1:0] status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient) && $stable(status))
      else $error("Stalled response item changed.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == md_pkg::MD_ST_OK || status == md_pkg::MD_ST_DIV0 ||
                     status == md_pkg::MD_ST_OVF))
      else $error("Undefined status code.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != md_pkg::MD_ST_OK |-> quotient == '0)
      else $error("Failed item carries a non-zero quotient.");

endmodule

bind muldiv_64_by_32_top md_checker u_md_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .quotient  (rsp_if.quotient),
   .status    (rsp_if.status)
);
